/* rtl/assert_macros.svh */
// Assertion macros shared by the allocator RTL.
// Expects i_clk and i_rst_n in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define FBPA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that an expression is never true outside reset.
`define FBPA_NEVER(lbl, expr, msg) \
    `FBPA_ASSERT(lbl, !(expr), msg)

`endif

/* rtl/fbpa_pkg.sv */
// Shared types and constants of the fixed block pool allocator.
// No dependencies.
package fbpa_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int DEPTH_W    = $clog2(MAX_BLOCKS + 1);
    localparam int ADDR_W     = 32;
    localparam int LOG2_W     = 4;
    localparam int CNT_W      = 7;
    localparam int MASK_W     = 12;
    localparam int SPAN_W     = CNT_W + MASK_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [LOG2_W-1:0]  LOG2_LIMIT      = LOG2_W'(MASK_W);
    localparam logic [ADDR_W-1:0]  RST_POOL_BASE   = 32'd4096;
    localparam logic [LOG2_W-1:0]  RST_BLOCK_LOG2  = 4'd4;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX       = DEPTH_W'(MAX_BLOCKS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_BASE       = 2'd0,
        CFG_BLOCK_SIZE_LOG2 = 2'd1,
        CFG_BLOCK_COUNT     = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OOM      = 2'd1,
        ST_BAD_FREE = 2'd2
    } t_status;

    typedef struct packed {
        logic              req_type;
        logic [ADDR_W-1:0] free_address;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] block_address;
        t_status           status;
    } t_rsp;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

/* rtl/fixed_block_pool_allocator_core.sv */
// Channel  Direction  Handshake                 Payload
// req      in         i_req_valid/o_req_ready   t_req (req_type, free_address)
// rsp      out        o_rsp_valid/i_rsp_ready   t_rsp (block_address, status)
// cfg      in         i_cfg_we                  i_cfg_idx, i_cfg_data
// An item is accepted, which starts the free-stack RAM read, then looked up and committed.
// The free-stack RAM read is registered, hence the separate lookup state.
// A new item is accepted while a finished result waits in the output register.
// A stalled result holds the sequencer in its lookup state until the output drains.
// Synchronous active-low reset; the free stack needs no clearing pass.
// Top level of the fixed block pool allocator; depends on fbpa_pkg, fbpa_ctrl, fbpa_dp.
module fixed_block_pool_allocator_core
    import fbpa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    input  t_req                  i_req,
    output logic                  o_rsp_valid,
    input  logic                  i_rsp_ready,
    output t_rsp                  o_rsp
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    fbpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    fbpa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

endmodule

/* rtl/fbpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fbpa_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/fbpa_ctrl.sv */
// Request sequencer of the allocator: capture, look up, commit.
// Depends on fbpa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fbpa_ctrl
    import fbpa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LOOK = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_req_ready = (r_state == S_IDLE);
    assign o_cmd.capture = i_req_valid && o_req_ready;
    assign o_cmd.commit  = (r_state == S_LOOK) && i_sts.out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.capture) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (o_cmd.commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `FBPA_ASSERT(a_one_in_flight, o_cmd.capture |=> !o_cmd.capture, "item accepted while busy")
    `FBPA_ASSERT(a_capture_then_look, o_cmd.capture |=> (r_state == S_LOOK), "no lookup after accept")

endmodule

/* rtl/fbpa_dp.sv */
// Allocator datapath: config registers, free stack, in-use map, result register.
// Depends on fbpa_pkg, fbpa_ram and assert_macros.svh.
`include "assert_macros.svh"

module fbpa_dp
    import fbpa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_req                  i_req,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output logic                  o_rsp_valid,
    input  logic                  i_rsp_ready,
    output t_rsp                  o_rsp
);

    logic [ADDR_W-1:0]     r_pool_base;
    logic [LOG2_W-1:0]     r_log2;
    logic [DEPTH_W-1:0]    r_count;
    logic [DEPTH_W-1:0]    r_depth;
    logic [MAX_BLOCKS-1:0] r_in_use;
    logic [MAX_BLOCKS-1:0] r_stk_vld;
    logic                  r_req_type;
    logic                  r_addr_nz;
    logic [ADDR_W-1:0]     r_off;
    logic [IDX_W-1:0]      r_rd_addr;
    logic                  r_rd_vld;
    t_rsp                  r_out;
    logic                  r_out_valid;

    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      ram_rdata;
    logic [IDX_W-1:0]      stk_idx;
    logic [LOG2_W-1:0]     eff_sh;
    logic [SPAN_W-1:0]     span;
    logic [MASK_W-1:0]     lo_mask;
    logic [ADDR_W-1:0]     off_shr;
    logic [IDX_W-1:0]      free_idx;
    logic                  alloc_ok;
    logic                  free_ok;
    logic [ADDR_W-1:0]     alloc_addr;
    logic [DEPTH_W-1:0]    cfg_count;
    logic [CNT_W-1:0]      cfg_raw;
    t_rsp                  n_out;

    assign rd_addr  = IDX_W'(r_depth - DEPTH_W'(1));
    assign eff_sh   = (r_log2 > LOG2_LIMIT) ? LOG2_LIMIT : r_log2;
    assign stk_idx  = r_rd_vld ? ram_rdata : r_rd_addr;
    assign alloc_ok = (r_depth != '0);
    assign alloc_addr = r_pool_base + (ADDR_W'(stk_idx) << eff_sh);

    assign span     = SPAN_W'(r_count) << eff_sh;
    assign lo_mask  = ~({MASK_W{1'b1}} << eff_sh);
    assign off_shr  = r_off >> eff_sh;
    assign free_idx = off_shr[IDX_W-1:0];
    assign free_ok  = r_addr_nz
                   && ((r_off[MASK_W-1:0] & lo_mask) == '0)
                   && (r_off[ADDR_W-1:SPAN_W] == '0)
                   && (r_off[SPAN_W-1:0] < span)
                   && r_in_use[free_idx]
                   && (r_depth < DEPTH_MAX);

    assign cfg_raw = i_cfg_data[CNT_W-1:0];
    always_comb begin
        priority if (cfg_raw == '0) begin
            cfg_count = DEPTH_W'(1);
        end else if (DEPTH_W'(cfg_raw) > DEPTH_MAX) begin
            cfg_count = DEPTH_MAX;
        end else begin
            cfg_count = DEPTH_W'(cfg_raw);
        end
    end

    always_comb begin
        n_out.block_address = '0;
        n_out.status        = ST_OK;
        if (!r_req_type) begin
            if (alloc_ok) begin
                n_out.block_address = alloc_addr;
            end else begin
                n_out.status = ST_OOM;
            end
        end else if (!free_ok) begin
            n_out.status = ST_BAD_FREE;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_rsp_ready;
    assign o_rsp_valid    = r_out_valid;
    assign o_rsp          = r_out;

    fbpa_ram #(
        .DATA_W (IDX_W),
        .DEPTH  (MAX_BLOCKS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && r_req_type && free_ok),
        .i_waddr (r_depth[IDX_W-1:0]),
        .i_wdata (free_idx),
        .i_re    (i_cmd.capture),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_type <= i_req.req_type;
            r_addr_nz  <= (i_req.free_address != '0);
            r_off      <= i_req.free_address - r_pool_base;
            r_rd_addr  <= rd_addr;
            r_rd_vld   <= r_stk_vld[rd_addr];
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base <= RST_POOL_BASE;
            r_log2      <= RST_BLOCK_LOG2;
            r_count     <= DEPTH_MAX;
            r_depth     <= DEPTH_MAX;
            r_in_use    <= '0;
            r_stk_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.commit && !r_req_type && alloc_ok) begin
                r_depth           <= r_depth - DEPTH_W'(1);
                r_in_use[stk_idx] <= 1'b1;
            end
            if (i_cmd.commit && r_req_type && free_ok) begin
                r_depth                       <= r_depth + DEPTH_W'(1);
                r_in_use[free_idx]            <= 1'b0;
                r_stk_vld[r_depth[IDX_W-1:0]] <= 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_POOL_BASE: begin
                        r_pool_base <= i_cfg_data[ADDR_W-1:0];
                    end
                    CFG_BLOCK_SIZE_LOG2: begin
                        r_log2 <= i_cfg_data[LOG2_W-1:0];
                    end
                    CFG_BLOCK_COUNT: begin
                        r_count   <= cfg_count;
                        r_depth   <= cfg_count;
                        r_in_use  <= '0;
                        r_stk_vld <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    `FBPA_NEVER(a_depth_bound, r_depth > DEPTH_MAX, "free stack depth above pool size")
    `FBPA_ASSERT(a_alloc_marks, (i_cmd.commit && !r_req_type && alloc_ok) |=> r_in_use[$past(stk_idx)], "allocated block not marked")
    `FBPA_ASSERT(a_free_pushes, (i_cmd.commit && r_req_type && free_ok) |=> (r_depth == $past(r_depth) + DEPTH_W'(1)), "free did not push")
    `FBPA_ASSERT(a_no_overwrite, i_cmd.commit |-> o_sts.out_free, "result overwritten")

endmodule

/* verif/fbpa_response_checker.sv */
`timescale 1ns / 100ps
// Response checker for the fixed block pool allocator: mirrors the registers, free stack
// and in-use map, predicts every response and compares it with what the block returns.
// Depends on fbpa_pkg.
module fbpa_response_checker
    import fbpa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  t_req                  i_req,
    input  logic                  i_rsp_valid,
    input  logic                  i_rsp_ready,
    input  t_rsp                  i_rsp,
    output int                    o_fail_count,
    output int                    o_outstanding
);
    logic [ADDR_W-1:0]     base_q;
    logic [LOG2_W-1:0]     log2_q;
    logic [CNT_W-1:0]      count_q;
    logic [IDX_W-1:0]      free_idx [MAX_BLOCKS];
    logic [DEPTH_W-1:0]    free_top;
    logic [MAX_BLOCKS-1:0] taken;
    t_rsp                  awaited_rsp [$];
    int                    fails = 0;

    function automatic void refill_pool();
        for (int i = 0; i < MAX_BLOCKS; i++) free_idx[i] = IDX_W'(i);
        taken    = '0;
        free_top = DEPTH_W'(count_q);
    endfunction

    function automatic logic [CNT_W-1:0] clamp_blocks(input logic [CNT_W-1:0] v);
        if (v == '0) return CNT_W'(1);
        if (v > MAX_BLOCKS) return CNT_W'(MAX_BLOCKS);
        return v;
    endfunction

    function automatic t_rsp serve_request(input t_req r);
        t_rsp              rsp;
        logic [LOG2_W-1:0] sh;
        logic [ADDR_W-1:0] off;
        logic [IDX_W-1:0]  idx;
        logic [63:0]       span;
        logic              ok;
        sh = (log2_q > LOG2_LIMIT) ? LOG2_LIMIT : log2_q;
        rsp.block_address = '0;
        rsp.status        = ST_OK;
        if (!r.req_type) begin
            if (free_top == '0) begin
                rsp.status = ST_OOM;
            end else begin
                free_top          = free_top - 1'b1;
                idx               = free_idx[free_top];
                taken[idx]        = 1'b1;
                rsp.block_address = base_q + (ADDR_W'(idx) << sh);
            end
        end else begin
            off  = r.free_address - base_q;
            span = 64'(count_q) << sh;
            ok   = (r.free_address != '0) && ((off & ((32'd1 << sh) - 32'd1)) == '0)
                   && (64'(off) < span);
            idx  = '0;
            if (ok) begin
                idx = IDX_W'(off >> sh);
                ok  = taken[idx] && (free_top < DEPTH_MAX);
            end
            if (ok) begin
                free_idx[free_top] = idx;
                free_top           = free_top + 1'b1;
                taken[idx]         = 1'b0;
            end else begin
                rsp.status = ST_BAD_FREE;
            end
        end
        return rsp;
    endfunction

    always @(posedge i_clk) begin : watch
        t_rsp want;
        if (!i_rst_n) begin
            base_q  = RST_POOL_BASE;
            log2_q  = RST_BLOCK_LOG2;
            count_q = clamp_blocks(CNT_W'(MAX_BLOCKS));
            refill_pool();
            awaited_rsp.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POOL_BASE:       base_q = i_cfg_data;
                    CFG_BLOCK_SIZE_LOG2: log2_q = i_cfg_data[LOG2_W-1:0];
                    CFG_BLOCK_COUNT: begin
                        count_q = clamp_blocks(i_cfg_data[CNT_W-1:0]);
                        refill_pool();
                    end
                    default: ;
                endcase
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (awaited_rsp.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected response: addr=%h st=%0d",
                                 i_rsp.block_address, i_rsp.status);
                end else begin
                    want = awaited_rsp.pop_front();
                    if (i_rsp.block_address !== want.block_address ||
                        i_rsp.status !== want.status) begin
                        fails++;
                        if (fails <= 10)
                            $display("response mismatch: want addr=%h st=%0d, got addr=%h st=%0d",
                                     want.block_address, want.status,
                                     i_rsp.block_address, i_rsp.status);
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                awaited_rsp = {awaited_rsp, serve_request(i_req)};
        end
        o_fail_count  <= fails;
        o_outstanding <= awaited_rsp.size();
    end

endmodule

/* verif/tb_fixed_block_pool_allocator_core.sv */
`timescale 1ns / 100ps
// Testbench top for fixed_block_pool_allocator_core: drives allocate and free traffic
// under changing pool settings and idle patterns; fbpa_response_checker does the checking.
// Depends on fbpa_pkg, fbpa_response_checker and the allocator RTL.
module tb_fixed_block_pool_allocator_core;
    import fbpa_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 4;
    localparam int SEGMENTS      = 5;
    localparam int SEGMENT_ITEMS = 85;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_req_valid = 1'b0;
    t_req                  i_req       = '0;
    logic                  i_rsp_ready = 1'b0;
    logic                  o_req_ready;
    logic                  o_rsp_valid;
    t_rsp                  o_rsp;

    int fail_count;
    int outstanding;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asks      = 0;

    logic [ADDR_W-1:0] pool_base_w = RST_POOL_BASE;
    logic [LOG2_W-1:0] log2_w      = RST_BLOCK_LOG2;
    logic [CNT_W-1:0]  count_w     = CNT_W'(MAX_BLOCKS);

    fixed_block_pool_allocator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    fbpa_response_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_req_valid   (i_req_valid),
        .i_req_ready   (o_req_ready),
        .i_req         (i_req),
        .i_rsp_valid   (o_rsp_valid),
        .i_rsp_ready   (i_rsp_ready),
        .i_rsp         (o_rsp),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin : rsp_side
        int served;
        served = 0;
        forever begin
            @(posedge i_clk);
            if (hold_asks != served) begin
                served++;
                i_rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [LOG2_W-1:0] cur_shift();
        return (log2_w > LOG2_LIMIT) ? LOG2_LIMIT : log2_w;
    endfunction

    function automatic logic [ADDR_W-1:0] block_addr(input int unsigned idx);
        return pool_base_w + (ADDR_W'(idx) << cur_shift());
    endfunction

    function automatic logic [ADDR_W-1:0] pick_free_addr();
        logic [LOG2_W-1:0] sh;
        int unsigned       roll;
        sh   = cur_shift();
        roll = $urandom_range(99);
        if (roll < 70) return block_addr($urandom_range(count_w - 1));
        if (roll < 78) return block_addr(count_w);
        if (roll < 86 && sh != '0)
            return block_addr($urandom_range(count_w - 1)) + $urandom_range((1 << sh) - 1, 1);
        if (roll < 90) return '0;
        if (roll < 95) return pool_base_w - ADDR_W'($urandom_range(64, 1));
        return $urandom;
    endfunction

    task automatic offer(input logic kind, input logic [ADDR_W-1:0] addr);
        t_req r;
        r.req_type     = kind;
        r.free_address = addr;
        while ($urandom_range(99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_POOL_BASE:       pool_base_w = data;
            CFG_BLOCK_SIZE_LOG2: log2_w = data[LOG2_W-1:0];
            CFG_BLOCK_COUNT: begin
                count_w = data[CNT_W-1:0];
                if (count_w == '0) count_w = CNT_W'(1);
                if (count_w > MAX_BLOCKS) count_w = CNT_W'(MAX_BLOCKS);
            end
            default: ;
        endcase
    endtask

    task automatic shuffle_config();
        logic [ADDR_W-1:0]     base;
        logic [LOG2_W-1:0]     lg;
        logic [CFG_DATA_W-1:0] cnt;
        case ($urandom_range(4))
            0:       base = '0;
            1:       base = 32'hFFFF_FFFF - $urandom_range(2047);
            default: base = $urandom;
        endcase
        cfg_write(CFG_POOL_BASE, base);
        case ($urandom_range(5))
            0:       lg = '0;
            1:       lg = LOG2_LIMIT;
            2:       lg = LOG2_W'($urandom_range(15, 13));
            default: lg = LOG2_W'($urandom_range(8));
        endcase
        cfg_write(CFG_BLOCK_SIZE_LOG2,
                  $urandom_range(1) ? {$urandom} & ~32'hF | 32'(lg) : 32'(lg));
        if ($urandom_range(3) != 0) begin
            case ($urandom_range(9))
                0:       cnt = '0;
                1:       cnt = 32'd1;
                2:       cnt = MAX_BLOCKS;
                3:       cnt = $urandom_range(127, MAX_BLOCKS + 1);
                default: cnt = $urandom_range(12, 2);
            endcase
            cfg_write(CFG_BLOCK_COUNT, cnt);
        end
        if ($urandom_range(3) == 0) cfg_write(CFG_UNMAPPED, $urandom);
    endtask

    task automatic run_traffic(input int n);
        int alloc_pct;
        alloc_pct = 50;
        for (int k = 0; k < n; k++) begin
            if (k % 16 == 0) alloc_pct = $urandom_range(80, 20);
            if ($urandom_range(99) < alloc_pct) offer(REQ_ALLOC, $urandom);
            else offer(REQ_FREE, pick_free_addr());
        end
    endtask

    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        offer(REQ_ALLOC, '0);
        offer(REQ_FREE, 32'h0000_13F0);
        offer(REQ_FREE, 32'h0000_13F0);
        offer(REQ_FREE, '0);
        offer(REQ_FREE, 32'h0000_13F1);
        offer(REQ_FREE, 32'h0000_1400);
        offer(REQ_FREE, 32'h0000_0FF0);
        offer(REQ_FREE, 32'hFFFF_FFFF);
        offer(REQ_ALLOC, 32'hFFFF_FFFF);
        wait_idle();
        cfg_write(CFG_BLOCK_COUNT, 32'd1);
        offer(REQ_ALLOC, '0);
        offer(REQ_ALLOC, '0);
        offer(REQ_FREE, RST_POOL_BASE);
        offer(REQ_ALLOC, '0);
        wait_idle();
        cfg_write(CFG_POOL_BASE, 32'hFFFF_FFF0);
        cfg_write(CFG_BLOCK_SIZE_LOG2, 32'd4);
        cfg_write(CFG_BLOCK_COUNT, 32'd2);
        offer(REQ_ALLOC, '0);
        offer(REQ_ALLOC, '0);
        offer(REQ_FREE, '0);
        offer(REQ_FREE, 32'hFFFF_FFF0);
        wait_idle();
        cfg_write(CFG_POOL_BASE, 32'h8000_0000);
        cfg_write(CFG_BLOCK_SIZE_LOG2, 32'hFFFF_FFFF);
        cfg_write(CFG_BLOCK_COUNT, 32'd100);
        offer(REQ_ALLOC, '0);
        offer(REQ_FREE, 32'h8003_F000);
        wait_idle();
        cfg_write(CFG_BLOCK_SIZE_LOG2, 32'd0);
        cfg_write(CFG_BLOCK_COUNT, 32'd0);
        offer(REQ_ALLOC, '0);
        offer(REQ_FREE, 32'h8000_0001);
        offer(REQ_FREE, 32'h8000_0000);
        wait_idle();
        cfg_write(CFG_UNMAPPED, 32'h5A5A_A5A5);
        offer(REQ_ALLOC, '0);
        wait_idle();
        cfg_write(CFG_BLOCK_SIZE_LOG2, 32'd12);
        offer(REQ_FREE, 32'h8000_1000);
        offer(REQ_FREE, 32'h8000_0000);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct <= 47; recv_stall_pct <= 0;  end
                2: begin send_idle_pct <= 0;  recv_stall_pct <= 47; end
                default: begin send_idle_pct <= 30; recv_stall_pct <= 30; end
            endcase
            for (int s = 0; s < SEGMENTS; s++) begin
                wait_idle();
                shuffle_config();
                if (phase == 0 && s == 1) hold_asks <= hold_asks + 1;
                run_traffic(SEGMENT_ITEMS);
            end
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/fbpa_pkg.sv
rtl/fbpa_ram.sv
rtl/fbpa_ctrl.sv
rtl/fbpa_dp.sv
rtl/fixed_block_pool_allocator_core.sv
verif/fbpa_response_checker.sv
verif/tb_fixed_block_pool_allocator_core.sv
